@@ hdl/mfa_pkg.sv @@
// Package for the modular field ALU: operation codes, pipeline geometry and
// the restoring remainder step shared by the reduction and divide stages.
// No dependencies.
`timescale 1ns / 1ps

package mfa_pkg;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_REM = 3'd3;
   localparam logic [2:0] MODE_CMP = 3'd4;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BITS_STEP  = 4;
   localparam int unsigned RED_STAGES = WORD_W / BITS_STEP;
   localparam int unsigned DIV_STAGES = (2 * WORD_W) / BITS_STEP;
   localparam logic [WORD_W-1:0] ORDER_MIN = 32'd2;

   // one restoring step: shift in a bit, subtract the divisor if it fits
   function automatic logic [WORD_W-1:0] rem_step(input logic [WORD_W-1:0] r,
                                                   input logic din,
                                                   input logic [WORD_W-1:0] d);
      logic [WORD_W:0] t;
      t = {r, din};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[WORD_W-1:0];
   endfunction

   // BITS_STEP steps, most significant bit first
   function automatic logic [WORD_W-1:0] rem_chunk(input logic [WORD_W-1:0] r,
                                                    input logic [BITS_STEP-1:0] bits,
                                                    input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] acc;
      acc = r;
      for (int i = BITS_STEP - 1; i >= 0; i--) begin
         acc = rem_step(acc, bits[i], d);
      end
      return acc;
   endfunction

endpackage

@@ hdl/mfa_if.sv @@
// Channel interfaces for the modular field ALU: request, response and
// register write. Depends on nothing.
`timescale 1ns / 1ps

interface mfa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] operand_a;
   logic signed [31:0] operand_b;
   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface mfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        less_than;
   logic        equal;
   logic        greater_than;
   logic        div_zero_error;
   modport source (output valid, value, less_than, equal, greater_than,
                   div_zero_error, input ready);
   modport sink   (input valid, value, less_than, equal, greater_than,
                   div_zero_error, output ready);
endinterface

interface mfa_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hdl/modular_field_alu.sv @@
// Modular field ALU top level: operand reduction, arithmetic and final
// remainder, all as a stall-able pipeline. Uses mfa_pkg and the mfa_*_if
// interfaces.
//
//   channel | dir | interface  | carries
//   req     | in  | mfa_req_if | mode, operand_a, operand_b
//   rsp     | out | mfa_rsp_if | value, compare flags, div_zero_error
//   csr     | in  | mfa_csr_if | field_order
//
// One word per cycle while the output word is not stalled; rsp.valid is registered.
// Depth set by the restoring dividers: 8 stages reduce both operands mod the
// order, 16 stages reduce the 64-bit product (and a mod b) at 4 bits a stage.
// Synchronous reset clears valids and loads a field order of 2.
// The whole pipe advances when the output register is empty or taken; a
// stalled output word freezes every stage, bubbles included.
`timescale 1ns / 1ps

module modular_field_alu (
   input  logic      clock,
   input  logic      reset,
   mfa_req_if.sink   req,
   mfa_rsp_if.source rsp,
   mfa_csr_if.sink   csr
);

   localparam int unsigned W  = mfa_pkg::WORD_W;
   localparam int unsigned NR = mfa_pkg::RED_STAGES;
   localparam int unsigned ND = mfa_pkg::DIV_STAGES;
   localparam int unsigned BS = mfa_pkg::BITS_STEP;

   logic [W-1:0] order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= mfa_pkg::ORDER_MIN;
      end else if (csr.valid && csr.ready) begin
         order_ff <= (csr.data < mfa_pkg::ORDER_MIN) ? mfa_pkg::ORDER_MIN : csr.data;
      end
   end
   assign csr.ready = 1'b1;

   // stall: all stages move together
   logic out_vld_ff;
   logic adv;
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------- operand reduction ----------------
   logic         red_vld_ff  [0:NR];
   logic [2:0]   red_mode_ff [0:NR];
   logic [W-1:0] red_a_ff    [0:NR];
   logic [W-1:0] red_b_ff    [0:NR];
   logic         red_neg_ff  [0:NR];
   logic [W-1:0] red_ra_ff   [0:NR];
   logic [W-1:0] red_rb_ff   [0:NR];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NR; k++) begin
            red_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         red_vld_ff[0] <= req.valid;
         for (int k = 0; k < NR; k++) begin
            red_vld_ff[k+1] <= red_vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_mode_ff[0] <= req.mode;
         red_a_ff[0]    <= req.operand_a;
         red_neg_ff[0]  <= req.operand_b[W-1];
         red_b_ff[0]    <= req.operand_b[W-1] ? (~req.operand_b + 1'b1) : req.operand_b;
         red_ra_ff[0]   <= '0;
         red_rb_ff[0]   <= '0;
         for (int k = 0; k < NR; k++) begin
            red_mode_ff[k+1] <= red_mode_ff[k];
            red_neg_ff[k+1]  <= red_neg_ff[k];
            red_a_ff[k+1]    <= red_a_ff[k] << BS;
            red_b_ff[k+1]    <= red_b_ff[k] << BS;
            red_ra_ff[k+1]   <= mfa_pkg::rem_chunk(red_ra_ff[k], red_a_ff[k][W-1 -: BS],
                                                   order_ff);
            red_rb_ff[k+1]   <= mfa_pkg::rem_chunk(red_rb_ff[k], red_b_ff[k][W-1 -: BS],
                                                   order_ff);
         end
      end
   end

   // ---------------- sign fix ----------------
   logic         fx_vld_ff;
   logic [2:0]   fx_mode_ff;
   logic [W-1:0] fx_a_ff;
   logic [W-1:0] fx_b_ff;
   logic [W-1:0] fx_b_in;

   assign fx_b_in = (red_neg_ff[NR] && (red_rb_ff[NR] != '0)) ?
                    (order_ff - red_rb_ff[NR]) : red_rb_ff[NR];

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_vld_ff <= 1'b0;
      end else if (adv) begin
         fx_vld_ff <= red_vld_ff[NR];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_mode_ff <= red_mode_ff[NR];
         fx_a_ff    <= red_ra_ff[NR];
         fx_b_ff    <= fx_b_in;
      end
   end

   // ---------------- arithmetic and final remainders ----------------
   logic [W:0]   sum_in;
   logic [W-1:0] add_in;
   logic [W-1:0] sub_in;

   assign sum_in = {1'b0, fx_a_ff} + {1'b0, fx_b_ff};
   assign add_in = (sum_in >= {1'b0, order_ff}) ? W'(sum_in - {1'b0, order_ff}) : sum_in[W-1:0];
   // wraps through 2^32 when a < b; result lands below the order
   assign sub_in = (fx_a_ff >= fx_b_ff) ? (fx_a_ff - fx_b_ff) : (fx_a_ff - fx_b_ff + order_ff);

   logic           dv_vld_ff  [0:ND];
   logic [2:0]     dv_mode_ff [0:ND];
   logic [2*W-1:0] dv_p_ff    [0:ND];
   logic [W-1:0]   dv_a_ff    [0:ND];
   logic [W-1:0]   dv_b_ff    [0:ND];
   logic [W-1:0]   dv_rp_ff   [0:ND];
   logic [W-1:0]   dv_rq_ff   [0:ND];
   logic [W-1:0]   dv_arith_ff[0:ND];
   logic [2:0]     dv_cmp_ff  [0:ND];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ND; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         dv_vld_ff[0] <= fx_vld_ff;
         for (int k = 0; k < ND; k++) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_mode_ff[0]  <= fx_mode_ff;
         dv_p_ff[0]     <= fx_a_ff * fx_b_ff;
         dv_a_ff[0]     <= fx_a_ff;
         dv_b_ff[0]     <= fx_b_ff;
         dv_rp_ff[0]    <= '0;
         dv_rq_ff[0]    <= '0;
         dv_arith_ff[0] <= (fx_mode_ff == mfa_pkg::MODE_SUB) ? sub_in : add_in;
         dv_cmp_ff[0]   <= {fx_a_ff < fx_b_ff, fx_a_ff == fx_b_ff, fx_a_ff > fx_b_ff};
         for (int k = 0; k < ND; k++) begin
            dv_mode_ff[k+1]  <= dv_mode_ff[k];
            dv_p_ff[k+1]     <= dv_p_ff[k] << BS;
            dv_b_ff[k+1]     <= dv_b_ff[k];
            dv_arith_ff[k+1] <= dv_arith_ff[k];
            dv_cmp_ff[k+1]   <= dv_cmp_ff[k];
            dv_rp_ff[k+1]    <= mfa_pkg::rem_chunk(dv_rp_ff[k], dv_p_ff[k][2*W-1 -: BS],
                                                   order_ff);
            // a mod b only needs 32 bits: idle for the first half of the stages
            if (k < ND / 2) begin
               dv_a_ff[k+1]  <= dv_a_ff[k];
               dv_rq_ff[k+1] <= '0;
            end else begin
               dv_a_ff[k+1]  <= dv_a_ff[k] << BS;
               dv_rq_ff[k+1] <= mfa_pkg::rem_chunk(dv_rq_ff[k], dv_a_ff[k][W-1 -: BS],
                                                   dv_b_ff[k]);
            end
         end
      end
   end

   // ---------------- result select ----------------
   logic [W-1:0] val_in;
   logic [2:0]   cmp_in;
   logic         err_in;

   always_comb begin
      val_in = '0;
      cmp_in = '0;
      err_in = 1'b0;
      unique case (dv_mode_ff[ND])
         mfa_pkg::MODE_ADD,
         mfa_pkg::MODE_SUB: val_in = dv_arith_ff[ND];
         mfa_pkg::MODE_MUL: val_in = dv_rp_ff[ND];
         mfa_pkg::MODE_REM: begin
            if (dv_b_ff[ND] == '0) begin
               err_in = 1'b1;
            end else begin
               val_in = dv_rq_ff[ND];
            end
         end
         mfa_pkg::MODE_CMP: cmp_in = dv_cmp_ff[ND];
         default: ;
      endcase
   end

   logic [W-1:0] val_ff;
   logic [2:0]   cmp_ff;
   logic         err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff <= val_in;
         cmp_ff <= cmp_in;
         err_ff <= err_in;
      end
   end

   assign rsp.valid          = out_vld_ff;
   assign rsp.value          = val_ff;
   assign rsp.less_than      = cmp_ff[2];
   assign rsp.equal          = cmp_ff[1];
   assign rsp.greater_than   = cmp_ff[0];
   assign rsp.div_zero_error = err_ff;

endmodule

@@ hdl/mfa_checker.sv @@
// Port-level checks for the modular field ALU, bound to the top level.
// Depends on modular_field_alu and its interfaces.
`timescale 1ns / 1ps

module mfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic        rsp_less_than,
   input logic        rsp_equal,
   input logic        rsp_greater_than,
   input logic        rsp_div_zero_error
);

   // at most one compare flag
   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_less_than, rsp_equal, rsp_greater_than}) <= 1)
      else $error("more than one compare flag");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero_error) |-> (rsp_value == '0) && !rsp_equal
         && !rsp_less_than && !rsp_greater_than)
      else $error("error word carries data");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_less_than || rsp_equal || rsp_greater_than)) |-> (rsp_value == '0))
      else $error("compare word carries a value");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_value))
      else $error("stalled response word dropped or changed");

endmodule

bind modular_field_alu mfa_checker u_mfa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_value          (rsp.value),
   .rsp_less_than      (rsp.less_than),
   .rsp_equal          (rsp.equal),
   .rsp_greater_than   (rsp.greater_than),
   .rsp_div_zero_error (rsp.div_zero_error)
);

@@ bench/modular_field_alu_tb.sv @@
// Testbench for the modular field ALU: drives requests and field-order writes,
// predicts each response and checks it in a scoreboard class.
// Depends on mfa_pkg, the mfa_*_if interfaces and modular_field_alu.
`timescale 1ns / 1ps

module modular_field_alu_tb;

   typedef struct packed {
      logic [31:0] value;
      logic        less_than;
      logic        equal;
      logic        greater_than;
      logic        div_zero_error;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type expected_q[$];
      logic [31:0] order;
      int          errors;

      function new();
         order  = 32'd2;
         errors = 0;
      endfunction

      function alu_result_type compute(logic [2:0] mode, logic [31:0] a_raw,
                                       logic signed [31:0] b_raw);
         alu_result_type r;
         logic [63:0] m, a, b;
         longint      bs;
         r  = '0;
         m  = (order < 32'd2) ? 64'd2 : {32'd0, order};
         a  = {32'd0, a_raw} % m;
         bs = longint'(b_raw) % longint'(m);
         if (bs < 0) bs = bs + longint'(m);
         b = 64'(bs);
         case (mode)
            mfa_pkg::MODE_ADD: r.value = 32'((a + b) % m);
            mfa_pkg::MODE_SUB: r.value = 32'((a + m - b) % m);
            mfa_pkg::MODE_MUL: r.value = 32'((a * b) % m);
            mfa_pkg::MODE_REM: begin
               if (b == 0) r.div_zero_error = 1'b1;
               else r.value = 32'(a % b);
            end
            mfa_pkg::MODE_CMP: begin
               r.less_than    = a < b;
               r.equal        = a == b;
               r.greater_than = a > b;
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(logic [2:0] mode, logic [31:0] a,
                                 logic signed [31:0] b);
         expected_q.push_back(compute(mode, a, b));
      endfunction

      function void check_response(alu_result_type got);
         alu_result_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word, actual %p", $time, got);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.value !== exp.value)
            $display("%0t: value expected %h actual %h", $time, exp.value, got.value);
         if (got.less_than !== exp.less_than)
            $display("%0t: less_than expected %b actual %b", $time,
                     exp.less_than, got.less_than);
         if (got.equal !== exp.equal)
            $display("%0t: equal expected %b actual %b", $time, exp.equal, got.equal);
         if (got.greater_than !== exp.greater_than)
            $display("%0t: greater_than expected %b actual %b", $time,
                     exp.greater_than, got.greater_than);
         if (got.div_zero_error !== exp.div_zero_error)
            $display("%0t: div_zero_error expected %b actual %b", $time,
                     exp.div_zero_error, got.div_zero_error);
         if (got !== exp) errors++;
      endfunction
   endclass

   logic clock, reset;
   mfa_req_if req ();
   mfa_rsp_if rsp ();
   mfa_csr_if csr ();

   modular_field_alu u_dut (.clock(clock), .reset(reset), .req(req.sink),
                            .rsp(rsp.source), .csr(csr.sink));

   alu_scoreboard sb;
   int  send_idle_pct, recv_idle_pct;
   bit  recv_hold;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random ready, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_response({rsp.value, rsp.less_than, rsp.equal, rsp.greater_than,
                            rsp.div_zero_error});
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("** modular_field_alu: FAILED **");
         $finish;
      end
   end

   // valid stays up between back-to-back words; it drops only while idling
   task automatic send_word(logic [2:0] mode, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.mode      <= mode;
      req.operand_a <= a;
      req.operand_b <= b;
      do @(posedge clock); while (!req.ready);
      sb.note_request(mode, a, b);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_order(logic [31:0] order);
      drain();
      csr.valid <= 1'b1;
      csr.data  <= order;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      sb.order = order;
   endtask

   function automatic logic [31:0] rand_operand(logic [31:0] order);
      case ($urandom_range(5))
         0: return $urandom_range(3);
         1: return order - $urandom_range(1);
         2: return 32'hFFFF_FFFF - $urandom_range(2);
         3: return 32'h8000_0000 + $urandom_range(1);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_words(int n);
      logic [2:0] mode;
      for (int i = 0; i < n; i++) begin
         mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                          : 3'($urandom_range(4));
         send_word(mode, rand_operand(sb.order), rand_operand(sb.order));
      end
   endtask

   initial begin
      logic [31:0] orders[8];
      sb = new();
      reset = 1'b1;
      req.valid = 1'b0; req.mode = '0; req.operand_a = '0; req.operand_b = '0;
      csr.valid = 1'b0; csr.data = '0;
      recv_hold = 1'b0; send_idle_pct = 10; recv_idle_pct = 85;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset order of 2, then extremes and special cases
      send_word(mfa_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      write_order(32'd7);
      for (int m = 0; m < 8; m++) send_word(3'(m), 32'd12, -32'sd3);
      send_word(mfa_pkg::MODE_REM, 32'd5, 32'sd14);
      send_word(mfa_pkg::MODE_CMP, 32'd9, 32'sd2);
      send_word(mfa_pkg::MODE_CMP, 32'd1, 32'sd5);
      write_order(32'hFFFF_FFFF);
      send_word(mfa_pkg::MODE_MUL, 32'hFFFF_FFFE, 32'h8000_0000);
      send_word(mfa_pkg::MODE_SUB, 32'd0, 32'hFFFF_FFFF);
      send_word(mfa_pkg::MODE_REM, 32'hFFFF_FFFF, 32'h0000_0000);
      write_order(32'd0);
      send_word(mfa_pkg::MODE_SUB, 32'd3, 32'sd1);
      write_order(32'd1);
      send_word(mfa_pkg::MODE_MUL, 32'd3, -32'sd1);

      orders = '{32'd2, 32'd3, 32'd13, 32'd65521, 32'h8000_0000,
                 32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'd100003};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin send_idle_pct = 85; recv_idle_pct = 10; end
         if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
         write_order(orders[ph]);
         if (ph == 6) begin
            // long receiver hold-off while the sender keeps offering
            fork
               begin
                  recv_hold <= 1'b1;
                  repeat (120) @(posedge clock);
                  recv_hold <= 1'b0;
               end
               random_words(50);
            join
         end else random_words(45);
      end
      drain();
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("** modular_field_alu: PASSED **");
      else
         $display("** modular_field_alu: FAILED **");
      $finish;
   end
endmodule

@@ modular_field_alu.f @@
hdl/mfa_pkg.sv
hdl/mfa_if.sv
hdl/modular_field_alu.sv
hdl/mfa_checker.sv
bench/modular_field_alu_tb.sv
